FILE: src/rie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rie_pkg;

  // Field widths
  localparam int unsigned XLEN       = 32;
  localparam int unsigned REG_IDX_W  = 5;
  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 80;

  // Instruction fields
  localparam logic [5:0] OPC_SPECIAL = 6'b000000;

  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [XLEN-1:0] LINK_OFFSET = 32'd8;

  // Decoded operation
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ADD,
    OP_ADDU,
    OP_SUB,
    OP_SUBU,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_SLL,
    OP_SRL,
    OP_SRA,
    OP_SLLV,
    OP_SRLV,
    OP_SRAV,
    OP_SLT,
    OP_SLTU,
    OP_MFHI,
    OP_MFLO,
    OP_MTHI,
    OP_MTLO,
    OP_JR,
    OP_JALR
  } op_e;

  // Decoded item carried from front to back
  typedef struct packed {
    op_e                  op;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] sa;
    logic [XLEN-1:0]      pc;
  } uop_t;

  // Result item
  typedef struct packed {
    logic [XLEN-1:0]      jump_target;
    logic                 jump_taken;
    logic [XLEN-1:0]      wb_value;
    logic [REG_IDX_W-1:0] wb_index;
    logic                 wb_valid;
    logic [1:0]           status;
  } result_t;

endpackage

`default_nettype wire

FILE: src/rie_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rie_front (
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [rie_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  output logic                                  push_o,
  input  wire logic                             push_ready_i,
  output rie_pkg::uop_t                         uop_o
);

  logic [rie_pkg::XLEN-1:0] instr;
  logic [5:0]               opcode;
  logic [5:0]               funct;

  assign instr  = s_tdata_i[rie_pkg::XLEN-1:0];
  assign opcode = instr[31:26];
  assign funct  = instr[5:0];

  // Handshake goes straight to the queue
  assign s_tready_o = push_ready_i;
  assign push_o     = s_tvalid_i;

  // Field extraction and function decode
  always_comb begin
    uop_o.rs = instr[25:21];
    uop_o.rt = instr[20:16];
    uop_o.rd = instr[15:11];
    uop_o.sa = instr[10:6];
    uop_o.pc = s_tdata_i[2*rie_pkg::XLEN-1:rie_pkg::XLEN];
    uop_o.op = rie_pkg::OP_NONE;
    if (opcode == rie_pkg::OPC_SPECIAL) begin
      unique case (funct)
        rie_pkg::FN_ADD:  uop_o.op = rie_pkg::OP_ADD;
        rie_pkg::FN_ADDU: uop_o.op = rie_pkg::OP_ADDU;
        rie_pkg::FN_SUB:  uop_o.op = rie_pkg::OP_SUB;
        rie_pkg::FN_SUBU: uop_o.op = rie_pkg::OP_SUBU;
        rie_pkg::FN_AND:  uop_o.op = rie_pkg::OP_AND;
        rie_pkg::FN_OR:   uop_o.op = rie_pkg::OP_OR;
        rie_pkg::FN_XOR:  uop_o.op = rie_pkg::OP_XOR;
        rie_pkg::FN_SLL:  uop_o.op = rie_pkg::OP_SLL;
        rie_pkg::FN_SRL:  uop_o.op = rie_pkg::OP_SRL;
        rie_pkg::FN_SRA:  uop_o.op = rie_pkg::OP_SRA;
        rie_pkg::FN_SLLV: uop_o.op = rie_pkg::OP_SLLV;
        rie_pkg::FN_SRLV: uop_o.op = rie_pkg::OP_SRLV;
        rie_pkg::FN_SRAV: uop_o.op = rie_pkg::OP_SRAV;
        rie_pkg::FN_SLT:  uop_o.op = rie_pkg::OP_SLT;
        rie_pkg::FN_SLTU: uop_o.op = rie_pkg::OP_SLTU;
        rie_pkg::FN_MFHI: uop_o.op = rie_pkg::OP_MFHI;
        rie_pkg::FN_MFLO: uop_o.op = rie_pkg::OP_MFLO;
        rie_pkg::FN_MTHI: uop_o.op = rie_pkg::OP_MTHI;
        rie_pkg::FN_MTLO: uop_o.op = rie_pkg::OP_MTLO;
        rie_pkg::FN_JR:   uop_o.op = rie_pkg::OP_JR;
        rie_pkg::FN_JALR: uop_o.op = rie_pkg::OP_JALR;
        default:          uop_o.op = rie_pkg::OP_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/rie_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rie_queue #(
  parameter int unsigned DEPTH = rie_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               push_ready_o,
  input  wire rie_pkg::uop_t push_uop_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output rie_pkg::uop_t      pop_uop_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rie_pkg::uop_t    slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != FULL_CNT);
  assign pop_valid_o  = (count_q != '0);
  assign pop_uop_o    = slot_q[rd_ptr_q];
  assign count_o      = count_q;

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_uop_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/rie_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rie_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  input  wire rie_pkg::uop_t q_uop_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rie_pkg::result_t   out_o
);

  localparam int unsigned XLEN  = rie_pkg::XLEN;
  localparam int unsigned IDX_W = rie_pkg::REG_IDX_W;

  // Register file memory with per-entry valid bits (unwritten reads zero)
  logic [XLEN-1:0]     gpr_mem [rie_pkg::NUM_REGS];
  logic [rie_pkg::NUM_REGS-1:0] gpr_vld_q;

  // Read stage
  logic                r_v_q;
  rie_pkg::uop_t       r_uop_q;
  logic [XLEN-1:0]     ra_q, rb_q;
  logic                va_q, vb_q;
  logic                byp_en_q;
  logic [IDX_W-1:0]    byp_idx_q;
  logic [XLEN-1:0]     byp_val_q;

  // hi / lo
  logic [XLEN-1:0]     hi_q, lo_q;

  // Output register
  logic                out_v_q;
  rie_pkg::result_t    out_q;

  logic                adv, take;
  logic [XLEN-1:0]     a, b, sum, diff, val, shl, shr, sar;
  logic [IDX_W-1:0]    shamt;
  logic                wr, wr_en, jmp;
  logic [1:0]          status;
  rie_pkg::result_t    res;

  assign adv     = r_v_q && (!out_v_q || out_ready_i);
  assign take    = q_valid_i && (!r_v_q || adv);
  assign q_pop_o = take;

  // Operands: bypass the write that retired on the read edge
  always_comb begin
    if (byp_en_q && byp_idx_q == r_uop_q.rs) begin
      a = byp_val_q;
    end else begin
      a = va_q ? ra_q : '0;
    end
    if (byp_en_q && byp_idx_q == r_uop_q.rt) begin
      b = byp_val_q;
    end else begin
      b = vb_q ? rb_q : '0;
    end
  end

  assign sum  = a + b;
  assign diff = a - b;

  // Shifter: immediate or rs-based amount
  always_comb begin
    if (r_uop_q.op == rie_pkg::OP_SLLV || r_uop_q.op == rie_pkg::OP_SRLV ||
        r_uop_q.op == rie_pkg::OP_SRAV) begin
      shamt = a[IDX_W-1:0];
    end else begin
      shamt = r_uop_q.sa;
    end
  end

  assign shl = b << shamt;
  assign shr = b >> shamt;
  assign sar = XLEN'($signed(b) >>> shamt);

  // Execute
  always_comb begin
    status = rie_pkg::ST_OK;
    val    = '0;
    wr     = 1'b0;
    jmp    = 1'b0;
    unique case (r_uop_q.op)
      rie_pkg::OP_ADD: begin
        if ((~(a[XLEN-1] ^ b[XLEN-1])) & (a[XLEN-1] ^ sum[XLEN-1])) begin
          status = rie_pkg::ST_OVF;
        end else begin
          val = sum;
          wr  = 1'b1;
        end
      end
      rie_pkg::OP_SUB: begin
        if ((a[XLEN-1] ^ b[XLEN-1]) & (a[XLEN-1] ^ diff[XLEN-1])) begin
          status = rie_pkg::ST_OVF;
        end else begin
          val = diff;
          wr  = 1'b1;
        end
      end
      rie_pkg::OP_ADDU: begin val = sum;   wr = 1'b1; end
      rie_pkg::OP_SUBU: begin val = diff;  wr = 1'b1; end
      rie_pkg::OP_AND:  begin val = a & b; wr = 1'b1; end
      rie_pkg::OP_OR:   begin val = a | b; wr = 1'b1; end
      rie_pkg::OP_XOR:  begin val = a ^ b; wr = 1'b1; end
      rie_pkg::OP_SLL,
      rie_pkg::OP_SLLV: begin val = shl; wr = 1'b1; end
      rie_pkg::OP_SRL,
      rie_pkg::OP_SRLV: begin val = shr; wr = 1'b1; end
      rie_pkg::OP_SRA,
      rie_pkg::OP_SRAV: begin val = sar; wr = 1'b1; end
      rie_pkg::OP_SLT: begin
        val = XLEN'($signed(a) < $signed(b));
        wr  = 1'b1;
      end
      rie_pkg::OP_SLTU: begin
        val = XLEN'(a < b);
        wr  = 1'b1;
      end
      rie_pkg::OP_MFHI: begin val = hi_q; wr = 1'b1; end
      rie_pkg::OP_MFLO: begin val = lo_q; wr = 1'b1; end
      rie_pkg::OP_MTHI,
      rie_pkg::OP_MTLO: ;
      rie_pkg::OP_JR:   jmp = 1'b1;
      rie_pkg::OP_JALR: begin
        jmp = 1'b1;
        val = r_uop_q.pc + rie_pkg::LINK_OFFSET;
        wr  = 1'b1;
      end
      default: status = rie_pkg::ST_NONE;
    endcase
  end

  // Writes to register zero are dropped
  assign wr_en = wr && (r_uop_q.rd != '0);

  always_comb begin
    res.status      = status;
    res.wb_valid    = wr_en;
    res.wb_index    = wr_en ? r_uop_q.rd : '0;
    res.wb_value    = wr_en ? val : '0;
    res.jump_taken  = jmp;
    res.jump_target = jmp ? a : '0;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Register file write and registered reads
  always_ff @(posedge clk_i) begin
    if (adv && wr_en) begin
      gpr_mem[r_uop_q.rd] <= val;
    end
    if (take) begin
      ra_q <= gpr_mem[q_uop_i.rs];
      rb_q <= gpr_mem[q_uop_i.rt];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_vld_q <= '0;
      r_v_q     <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      byp_en_q  <= 1'b0;
      out_v_q   <= 1'b0;
      hi_q      <= '0;
      lo_q      <= '0;
    end else begin
      if (adv && wr_en) begin
        gpr_vld_q[r_uop_q.rd] <= 1'b1;
      end
      if (adv && r_uop_q.op == rie_pkg::OP_MTHI) begin
        hi_q <= a;
      end
      if (adv && r_uop_q.op == rie_pkg::OP_MTLO) begin
        lo_q <= a;
      end
      if (take) begin
        r_v_q    <= 1'b1;
        va_q     <= gpr_vld_q[q_uop_i.rs];
        vb_q     <= gpr_vld_q[q_uop_i.rt];
        byp_en_q <= adv && wr_en;
      end else if (adv) begin
        r_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      r_uop_q   <= q_uop_i;
      byp_idx_q <= r_uop_q.rd;
      byp_val_q <= val;
    end
    if (adv) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

FILE: src/rtype_integer_execute_unit_core.sv
// R-type integer execute unit.
// Input stream (s_axis): one instruction per item, tdata = {pc, instr}.
// Output stream (m_axis): one result per instruction, in order: status,
// write-back register/value and register-jump target.
// The front decodes the function code and pushes a micro-op into a small
// queue (QUEUE_DEPTH entries); the back reads the 32 x 32 register file
// (registered read), executes, commits the register, hi and lo writes and
// loads the output register.
// An accepted instruction passes the queue slot, the read stage registers
// and the output register. Throughput: one instruction per cycle while the
// output is ready; the register file read port and a one-entry bypass of the
// write retiring on the read edge let dependent instructions follow back to back.
// Reset: queue and pipeline empty, all registers plus hi and lo read zero.
// When m_axis_tready_i is low the result holds, the back stops, the queue
// fills and s_axis_tready_o drops once it is full.
`timescale 1ns / 1ps
`default_nettype none

module rtype_integer_execute_unit_core #(
  parameter int unsigned QUEUE_DEPTH = rie_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [31:0] instr, [63:32] pc
  input  wire logic [rie_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [1:0] status, [2] wb_valid, [7:3] wb_index, [39:8] wb_value,
  // [40] jump_taken, [72:41] jump_target, [79:73] zero
  output logic [rie_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);

  localparam int unsigned RES_W = $bits(rie_pkg::result_t);

  logic                  push, push_ready, q_valid, q_pop;
  rie_pkg::uop_t         push_uop, q_uop;
  rie_pkg::result_t      result;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Decode front
  rie_front u_front (
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .uop_o        (push_uop)
  );

  // Decoupling queue
  rie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_uop_i   (push_uop),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_uop_o    (q_uop),
    .count_o      (q_count)
  );

  // Execute back
  rie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_uop_i     (q_uop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (result)
  );

  assign m_axis_tdata_o = {{(rie_pkg::OUT_TDATA_W-RES_W){1'b0}}, result};

`ifndef SYNTHESIS
  // Queue fill never passes its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // A reported write never targets register zero
  a_wb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && result.wb_valid |-> result.wb_index != '0)
    else $error("write-back to register zero");

  // Trap or unimplemented results carry no write and no jump
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && result.status != rie_pkg::ST_OK |->
      !result.wb_valid && !result.jump_taken)
    else $error("faulting item has side effects");

  // The queue only pops what it holds
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_rtype_integer_execute_unit_core.sv
`timescale 1ns / 1ps

module tb_rtype_integer_execute_unit_core;

  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLDOFF_AT     = 300;
  localparam int unsigned HOLDOFF_CYCLES = 60;
  localparam int unsigned DRAIN_AT       = 700;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned MAX_PRINTS     = 100;

  // Function codes the block leaves unimplemented
  localparam logic [5:0] FN_UNUSED = 6'd1;
  localparam logic [5:0] FN_MULT   = 6'd24;
  localparam logic [5:0] FN_MULTU  = 6'd25;
  localparam logic [5:0] FN_DIV    = 6'd26;
  localparam logic [5:0] FN_DIVU   = 6'd27;

  localparam logic [5:0] EXEC_FNS [21] = '{
    rie_pkg::FN_SLL, rie_pkg::FN_SRL, rie_pkg::FN_SRA, rie_pkg::FN_SLLV,
    rie_pkg::FN_SRLV, rie_pkg::FN_SRAV, rie_pkg::FN_JR, rie_pkg::FN_JALR,
    rie_pkg::FN_MFHI, rie_pkg::FN_MTHI, rie_pkg::FN_MFLO, rie_pkg::FN_MTLO,
    rie_pkg::FN_ADD, rie_pkg::FN_ADDU, rie_pkg::FN_SUB, rie_pkg::FN_SUBU,
    rie_pkg::FN_AND, rie_pkg::FN_OR, rie_pkg::FN_XOR, rie_pkg::FN_SLT,
    rie_pkg::FN_SLTU
  };
  localparam logic [5:0] MULDIV_FNS [4] = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU};
  localparam logic [31:0] CORNER_WORDS [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF
  };

  typedef struct {
    logic [31:0] instr;
    logic [31:0] pc;
    bit          wait_idle;  // hold this item until all results are back
  } instr_item_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_e;

  // DUT signals
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_valid = 1'b0;
  logic                            s_axis_tready_o;
  logic [rie_pkg::IN_TDATA_W-1:0]  s_data = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_ready = 1'b0;
  logic [rie_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow architectural state
  logic [31:0] gpr_shadow [32] = '{default: '0};
  logic [31:0] hi_shadow = '0;
  logic [31:0] lo_shadow = '0;

  instr_item_t      instr_q [$];
  rie_pkg::result_t result_q [$];
  instr_item_t      cur_item;
  rie_pkg::result_t got_res;
  rie_pkg::result_t want_res;

  int unsigned sent_cnt = 0;
  int unsigned total_items = 0;
  int unsigned checked_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  int unsigned stall_phase_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  rtype_integer_execute_unit_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Executes one instruction on the shadow state and returns its result
  function automatic rie_pkg::result_t exec_instr(logic [31:0] instr, logic [31:0] pc);
    rie_pkg::result_t res;
    logic [4:0]       rs, rt, rd, sa;
    logic [31:0]      a, b, r, val;
    logic             wr;
    res = '0;
    rs  = instr[25:21];
    rt  = instr[20:16];
    rd  = instr[15:11];
    sa  = instr[10:6];
    a   = gpr_shadow[rs];
    b   = gpr_shadow[rt];
    val = '0;
    wr  = 1'b0;
    res.status = rie_pkg::ST_OK;
    if (instr[31:26] != rie_pkg::OPC_SPECIAL) begin
      res.status = rie_pkg::ST_NONE;
    end else begin
      case (instr[5:0])
        rie_pkg::FN_ADD: begin
          r = a + b;
          if (!(a[31] ^ b[31]) && (a[31] ^ r[31])) res.status = rie_pkg::ST_OVF;
          else begin
            val = r;
            wr  = 1'b1;
          end
        end
        rie_pkg::FN_SUB: begin
          r = a - b;
          if ((a[31] ^ b[31]) && (a[31] ^ r[31])) res.status = rie_pkg::ST_OVF;
          else begin
            val = r;
            wr  = 1'b1;
          end
        end
        rie_pkg::FN_ADDU: {wr, val} = {1'b1, a + b};
        rie_pkg::FN_SUBU: {wr, val} = {1'b1, a - b};
        rie_pkg::FN_AND:  {wr, val} = {1'b1, a & b};
        rie_pkg::FN_OR:   {wr, val} = {1'b1, a | b};
        rie_pkg::FN_XOR:  {wr, val} = {1'b1, a ^ b};
        rie_pkg::FN_SLL:  {wr, val} = {1'b1, b << sa};
        rie_pkg::FN_SRL:  {wr, val} = {1'b1, b >> sa};
        rie_pkg::FN_SRA:  {wr, val} = {1'b1, 32'($signed(b) >>> sa)};
        rie_pkg::FN_SLLV: {wr, val} = {1'b1, b << a[4:0]};
        rie_pkg::FN_SRLV: {wr, val} = {1'b1, b >> a[4:0]};
        rie_pkg::FN_SRAV: {wr, val} = {1'b1, 32'($signed(b) >>> a[4:0])};
        rie_pkg::FN_SLT:  {wr, val} = {1'b1, 31'd0, ($signed(a) < $signed(b))};
        rie_pkg::FN_SLTU: {wr, val} = {1'b1, 31'd0, (a < b)};
        rie_pkg::FN_MFHI: {wr, val} = {1'b1, hi_shadow};
        rie_pkg::FN_MFLO: {wr, val} = {1'b1, lo_shadow};
        rie_pkg::FN_MTHI: hi_shadow = a;
        rie_pkg::FN_MTLO: lo_shadow = a;
        rie_pkg::FN_JR: begin
          res.jump_taken  = 1'b1;
          res.jump_target = a;
        end
        rie_pkg::FN_JALR: begin
          res.jump_taken  = 1'b1;
          res.jump_target = a;
          val = pc + rie_pkg::LINK_OFFSET;
          wr  = 1'b1;
        end
        default: res.status = rie_pkg::ST_NONE;
      endcase
    end
    // writes to register zero are dropped
    if (wr && rd != '0) begin
      gpr_shadow[rd] = val;
      res.wb_valid = 1'b1;
      res.wb_index = rd;
      res.wb_value = val;
    end
    return res;
  endfunction

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa);
    return {rie_pkg::OPC_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic void queue_instr(logic [31:0] instr, logic [31:0] pc, bit wait_idle);
    instr_item_t it;
    it.instr     = instr;
    it.pc        = pc;
    it.wait_idle = wait_idle;
    instr_q.push_back(it);
  endfunction

  // JALR from r0 links pc+8 into rd, which sets any register but r0 to any value
  function automatic void load_reg(logic [4:0] rd, logic [31:0] value);
    queue_instr(rtype(rie_pkg::FN_JALR, 5'd0, 5'd0, rd, 5'd0),
                value - rie_pkg::LINK_OFFSET, 1'b0);
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 3) == 0) return CORNER_WORDS[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // Favor low registers so that items often depend on the one before
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("ERROR result %0d: %s got %h want %h", checked_cnt, what, got, want);
  endtask

  // Driver: bursts of items with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        result_q.push_back(exec_instr(cur_item.instr, cur_item.pc));
        sent_cnt++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (instr_q.size() == 0 ||
                     (instr_q[0].wait_idle && result_q.size() != 0)) begin
          s_valid <= 1'b0;
        end else begin
          cur_item = instr_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {cur_item.pc, cur_item.instr};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver ready: one long hold-off, otherwise phases of stall patterns
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_ready <= 1'b0;
    end else if (!holdoff_done && sent_cnt >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
      m_ready <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = stall_mode_e'($urandom_range(0, 2));
        stall_phase_left = $urandom_range(10, 60);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        STALL_NONE: m_ready <= 1'b1;
        STALL_HALF: m_ready <= 1'($urandom_range(0, 1));
        default:    m_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_res = m_axis_tdata_o[$bits(rie_pkg::result_t)-1:0];
      if (result_q.size() == 0) begin
        report_mismatch("unexpected item", got_res.wb_value, '0);
      end else begin
        want_res = result_q.pop_front();
        if (got_res.status !== want_res.status)
          report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
        if (got_res.wb_valid !== want_res.wb_valid)
          report_mismatch("wb_valid", 32'(got_res.wb_valid), 32'(want_res.wb_valid));
        if (got_res.wb_index !== want_res.wb_index)
          report_mismatch("wb_index", 32'(got_res.wb_index), 32'(want_res.wb_index));
        if (got_res.wb_value !== want_res.wb_value)
          report_mismatch("wb_value", got_res.wb_value, want_res.wb_value);
        if (got_res.jump_taken !== want_res.jump_taken)
          report_mismatch("jump_taken", 32'(got_res.jump_taken),
                          32'(want_res.jump_taken));
        if (got_res.jump_target !== want_res.jump_target)
          report_mismatch("jump_target", got_res.jump_target, want_res.jump_target);
      end
      checked_cnt++;
    end
  end

  // Timeout
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int unsigned kind;
    logic [31:0] instr;
    logic [31:0] pc;

    // directed: corner operands, every operation and the special cases
    load_reg(5'd1, 32'h7FFF_FFFF);
    load_reg(5'd2, 32'h0000_0001);
    load_reg(5'd3, 32'h8000_0000);
    load_reg(5'd4, 32'hFFFF_FFFF);
    queue_instr(rtype(rie_pkg::FN_ADD,  5'd1, 5'd2, 5'd5,  5'd0),  32'h0000_1000, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SUB,  5'd3, 5'd2, 5'd6,  5'd0),  32'h0000_1004, 1'b0);
    queue_instr(rtype(rie_pkg::FN_ADDU, 5'd1, 5'd2, 5'd0,  5'd0),  32'h0000_1008, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SUBU, 5'd2, 5'd4, 5'd7,  5'd0),  32'h0000_100C, 1'b0);
    queue_instr(rtype(rie_pkg::FN_AND,  5'd3, 5'd4, 5'd8,  5'd0),  32'h0000_1010, 1'b0);
    queue_instr(rtype(rie_pkg::FN_OR,   5'd1, 5'd3, 5'd9,  5'd0),  32'h0000_1014, 1'b0);
    queue_instr(rtype(rie_pkg::FN_XOR,  5'd4, 5'd1, 5'd10, 5'd0),  32'h0000_1018, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SLL,  5'd0, 5'd4, 5'd11, 5'd31), 32'h0000_101C, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SRL,  5'd0, 5'd4, 5'd12, 5'd31), 32'h0000_1020, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SRA,  5'd0, 5'd3, 5'd13, 5'd31), 32'h0000_1024, 1'b0);
    // variable shifts take only the low five bits of rs
    queue_instr(rtype(rie_pkg::FN_SLLV, 5'd1, 5'd4, 5'd15, 5'd0),  32'h0000_1028, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SRLV, 5'd2, 5'd3, 5'd16, 5'd0),  32'h0000_102C, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SRAV, 5'd1, 5'd3, 5'd17, 5'd0),  32'h0000_1030, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SLT,  5'd3, 5'd2, 5'd18, 5'd0),  32'h0000_1034, 1'b0);
    queue_instr(rtype(rie_pkg::FN_SLTU, 5'd3, 5'd2, 5'd19, 5'd0),  32'h0000_1038, 1'b0);
    queue_instr(rtype(rie_pkg::FN_MTHI, 5'd3, 5'd0, 5'd0,  5'd0),  32'h0000_103C, 1'b0);
    queue_instr(rtype(rie_pkg::FN_MTLO, 5'd4, 5'd0, 5'd0,  5'd0),  32'h0000_1040, 1'b0);
    queue_instr(rtype(rie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd20, 5'd0),  32'h0000_1044, 1'b0);
    queue_instr(rtype(rie_pkg::FN_MFLO, 5'd0, 5'd0, 5'd21, 5'd0),  32'h0000_1048, 1'b0);
    queue_instr(rtype(rie_pkg::FN_JR,   5'd1, 5'd0, 5'd0,  5'd0),  32'h0000_104C, 1'b0);
    // link into rs itself, with pc+8 wrapping around
    queue_instr(rtype(rie_pkg::FN_JALR, 5'd4, 5'd0, 5'd4,  5'd0),  32'hFFFF_FFFC, 1'b0);
    queue_instr(rtype(FN_MULT, 5'd1, 5'd2, 5'd0,  5'd0),  32'h0000_1050, 1'b0);
    queue_instr(rtype(FN_UNUSED, 5'd1, 5'd2, 5'd22, 5'd0), 32'h0000_1054, 1'b0);
    queue_instr(32'hFFFF_FFFF, 32'h0000_1058, 1'b0);

    // random: mostly executable items, some register loads and some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind  = $urandom_range(0, 99);
      pc    = $urandom;
      instr = rtype(EXEC_FNS[$urandom_range(0, 20)], pick_reg(), pick_reg(), pick_reg(),
                    5'($urandom));
      if (kind < 15) begin
        instr = rtype(rie_pkg::FN_JALR, ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg(),
                      5'($urandom), pick_reg(), 5'($urandom));
        pc    = pick_word() - rie_pkg::LINK_OFFSET;
      end else if (kind < 85) begin
        // keep the executable item built above
      end else if (kind < 90) begin
        instr[5:0] = MULDIV_FNS[$urandom_range(0, 3)];
      end else if (kind < 95) begin
        instr[5:0] = 6'($urandom);
      end else begin
        instr = $urandom;
      end
      queue_instr(instr, pc, i == DRAIN_AT);
    end
    total_items = instr_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt != total_items || result_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rie_pkg.sv
src/rie_front.sv
src/rie_queue.sv
src/rie_back.sv
src/rtype_integer_execute_unit_core.sv
sim/tb_rtype_integer_execute_unit_core.sv
